FILE: hw/rtl/tsqes_pkg.sv
// Shared types, constants and time arithmetic for the two-server queue event simulator.
package tsqes_pkg;

    localparam int TIME_W         = 48;
    localparam int SAMPLE_W       = 32;
    localparam int CFG_INDEX_W    = 2;
    localparam int FIFO_DEPTH_DEF = 64;
    localparam int WCOUNT_W       = 7;

    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef enum logic [2:0] {
        EV_SERVED   = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_DROPPED  = 3'd2,
        EV_DEPART   = 3'd3,
        EV_FINISHED = 3'd4
    } event_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIRST_Q0 = 2'd0,
        CFG_FIRST_Q1 = 2'd1,
        CFG_TOTAL    = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_index_t;

    localparam sample_t FIRST_ARRIVAL_RST = 32'd65536;
    localparam sample_t TOTAL_RST         = 32'd1000000;

    // Saturating time plus sample.
    function automatic time_t time_add_sat(time_t a, sample_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + (TIME_W+1)'(b);
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    // Difference clamped at zero.
    function automatic time_t time_sub_clamp(time_t a, time_t b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

FILE: hw/rtl/two_server_queue_event_simulator.sv
// Top level of the two-server FIFO queue discrete-event simulator.
// s_ channel: one item per event, tdata = interarrival and service samples
//   (unsigned, 16 fraction bits). Each accepted item yields exactly one item on
//   the m_ channel and, until the departure total is met, advances one event.
// m_ channel: tuser carries the event kind, queue index and done flag; tdata
//   carries the event time, response, wait and service times and the FIFO fill.
// cfg channel: always ready; index 0/1 write the first arrival of queue 0/1
//   (and reschedule that arrival at once), index 2 the departure total. Write
//   only while no item is in flight.
// Timing: the earliest event is picked and registered at the accept edge; the
//   next cycle applies it and loads the output register, unless a stalled
//   result still holds it. A new item is taken only once the last one has
//   applied. A departure that pops a waiting arrival reads the FIFO memory;
//   its data lands in the following cycle, before the next item applies.
// Reset (aresetn low, synchronous): clock, servers, FIFO pointers and the
//   departure count clear; config registers get their defaults. The FIFO memory
//   needs no clearing pass, as only pushed entries are ever popped.
// Stall: the result waits in the output register; one more item can still be
//   accepted and picked, and it applies once the output register frees up.
module two_server_queue_event_simulator #(
    parameter int FIFO_DEPTH = tsqes_pkg::FIFO_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] interarrival_sample, [63:32] service_sample

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // [47:0] event_time, [95:48] response_time,
                                    // [143:96] wait_time, [191:144] service_time,
                                    // [198:192] waiting_count, [199] zero
    output logic [4:0]   m_tuser,   // [2:0] event_kind, [3] queue_index, [4] done_res

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int HW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int AW = $clog2(2 * FIFO_DEPTH);
    localparam int TW = tsqes_pkg::TIME_W;

    // ---------------- architectural state ----------------
    tsqes_pkg::sample_t total_reg,  total_next;

    tsqes_pkg::time_t sim_clock_reg, sim_clock_next;
    tsqes_pkg::time_t arr_reg [2];
    tsqes_pkg::time_t arr_next [2];
    logic             busy_reg [2];
    logic             busy_next [2];
    tsqes_pkg::time_t comp_reg [2];
    tsqes_pkg::time_t comp_next [2];
    tsqes_pkg::time_t sarr_reg [2];
    tsqes_pkg::time_t sarr_next [2];
    tsqes_pkg::time_t sstart_reg [2];
    tsqes_pkg::time_t sstart_next [2];
    logic [HW-1:0]    head_reg [2];
    logic [HW-1:0]    head_next [2];
    logic [CW-1:0]    count_reg [2];
    logic [CW-1:0]    count_next [2];
    logic [31:0]      dep_reg, dep_next;

    // ---------------- pick stage (item registered) ----------------
    logic               exec_reg, exec_next;
    logic               fin_reg;
    logic [1:0]         sel_reg;
    tsqes_pkg::time_t   best_reg;
    tsqes_pkg::sample_t ia_reg;
    tsqes_pkg::sample_t sv_reg;

    // Pending FIFO pop: memory data goes into the service arrival next cycle.
    logic pop_reg, pop_next;
    logic popq_reg, popq_next;

    // ---------------- output register ----------------
    logic                   m_valid_reg, m_valid_next;
    tsqes_pkg::event_kind_t m_kind_reg, m_kind_next;
    logic                   m_q_reg, m_q_next;
    tsqes_pkg::time_t       m_time_reg, m_time_next;
    tsqes_pkg::time_t       m_resp_reg, m_resp_next;
    tsqes_pkg::time_t       m_wait_reg, m_wait_next;
    tsqes_pkg::time_t       m_serv_reg, m_serv_next;
    logic [tsqes_pkg::WCOUNT_W-1:0] m_wcnt_reg, m_wcnt_next;
    logic                   m_done_reg, m_done_next;

    // ---------------- FIFO memory ----------------
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    tsqes_pkg::time_t ram_rdata;

    tsqes_ram #(
        .WIDTH(TW),
        .DEPTH(2 * FIFO_DEPTH)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (best_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- handshakes ----------------
    logic in_fire, exec_fire, cfg_fire;

    assign s_tready  = ~exec_reg;
    assign in_fire   = s_tvalid & s_tready;
    assign exec_fire = exec_reg & (~m_valid_reg | m_tready);
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // ---------------- event pick (all compares in parallel) ----------------
    logic             lt01, win0, win1;
    logic [1:0]       pick_sel;
    tsqes_pkg::time_t pick_t;

    always_comb begin
        lt01 = arr_reg[1] < arr_reg[0];
        // Busy server 0 beats the earlier arrival.
        win0 = busy_reg[0] & (lt01 ? (comp_reg[0] < arr_reg[1]) : (comp_reg[0] < arr_reg[0]));
        // Busy server 1 beats whatever won so far.
        win1 = busy_reg[1] & (win0 ? (comp_reg[1] < comp_reg[0]) :
               (lt01 ? (comp_reg[1] < arr_reg[1]) : (comp_reg[1] < arr_reg[0])));
        priority if (win1) begin
            pick_sel = 2'd3;
            pick_t   = comp_reg[1];
        end else if (win0) begin
            pick_sel = 2'd2;
            pick_t   = comp_reg[0];
        end else if (lt01) begin
            pick_sel = 2'd1;
            pick_t   = arr_reg[1];
        end else begin
            pick_sel = 2'd0;
            pick_t   = arr_reg[0];
        end
    end

    // ---------------- apply stage ----------------
    logic          q;
    logic          is_dep;
    logic [HW:0]   slot_sum;
    logic [HW-1:0] slot;
    logic [32:0]   dep_inc;
    logic [31:0]   wcnt32;

    always_comb begin
        q        = sel_reg[0];
        is_dep   = sel_reg[1];
        slot_sum = {1'b0, head_reg[q]} + (HW+1)'(count_reg[q]);
        slot     = (slot_sum >= (HW+1)'(FIFO_DEPTH)) ?
                   HW'(slot_sum - (HW+1)'(FIFO_DEPTH)) : HW'(slot_sum);
        dep_inc  = {1'b0, dep_reg} + 33'd1;

        // Hold everything by default.
        total_next     = total_reg;
        sim_clock_next = sim_clock_reg;
        for (int k = 0; k < 2; k++) begin
            arr_next[k]    = arr_reg[k];
            busy_next[k]   = busy_reg[k];
            comp_next[k]   = comp_reg[k];
            sarr_next[k]   = sarr_reg[k];
            sstart_next[k] = sstart_reg[k];
            head_next[k]   = head_reg[k];
            count_next[k]  = count_reg[k];
        end
        dep_next  = dep_reg;
        pop_next  = 1'b0;
        popq_next = popq_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = q ? (AW'(slot) + AW'(FIFO_DEPTH)) : AW'(slot);
        ram_raddr = q ? (AW'(head_reg[q]) + AW'(FIFO_DEPTH)) : AW'(head_reg[q]);

        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_q_next     = m_q_reg;
        m_time_next  = m_time_reg;
        m_resp_next  = m_resp_reg;
        m_wait_next  = m_wait_reg;
        m_serv_next  = m_serv_reg;
        m_wcnt_next  = m_wcnt_reg;
        m_done_next  = m_done_reg;
        wcnt32       = '0;

        // Land a popped arrival time from the memory.
        if (pop_reg) begin
            sarr_next[popq_reg] = ram_rdata;
        end

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        exec_next = exec_reg;
        if (in_fire) begin
            exec_next = 1'b1;
        end

        if (exec_fire) begin
            exec_next    = 1'b0;
            m_valid_next = 1'b1;
            m_resp_next  = '0;
            m_wait_next  = '0;
            m_serv_next  = '0;
            if (fin_reg) begin
                m_kind_next = tsqes_pkg::EV_FINISHED;
                m_q_next    = 1'b0;
                m_time_next = sim_clock_reg;
                m_wcnt_next = '0;
                m_done_next = 1'b1;
            end else begin
                sim_clock_next = best_reg;
                m_q_next       = q;
                m_time_next    = best_reg;
                m_done_next    = 1'b0;
                if (!is_dep) begin
                    if (!busy_reg[q]) begin
                        busy_next[q]   = 1'b1;
                        sarr_next[q]   = best_reg;
                        sstart_next[q] = best_reg;
                        comp_next[q]   = tsqes_pkg::time_add_sat(best_reg, sv_reg);
                        m_kind_next    = tsqes_pkg::EV_SERVED;
                    end else if (count_reg[q] < CW'(FIFO_DEPTH)) begin
                        ram_we        = 1'b1;
                        count_next[q] = count_reg[q] + CW'(1);
                        m_kind_next   = tsqes_pkg::EV_QUEUED;
                    end else begin
                        m_kind_next = tsqes_pkg::EV_DROPPED;
                    end
                    arr_next[q] = tsqes_pkg::time_add_sat(best_reg, ia_reg);
                end else begin
                    m_kind_next = tsqes_pkg::EV_DEPART;
                    m_resp_next = tsqes_pkg::time_sub_clamp(best_reg, sarr_reg[q]);
                    m_wait_next = tsqes_pkg::time_sub_clamp(sstart_reg[q], sarr_reg[q]);
                    m_serv_next = tsqes_pkg::time_sub_clamp(best_reg, sstart_reg[q]);
                    dep_next    = dep_inc[31:0];
                    priority if (dep_inc >= {1'b0, total_reg}) begin
                        // Final departure: keep the server and FIFO as they are.
                        m_done_next = 1'b1;
                    end else if (count_reg[q] == '0) begin
                        busy_next[q] = 1'b0;
                    end else begin
                        ram_re         = 1'b1;
                        pop_next       = 1'b1;
                        popq_next      = q;
                        head_next[q]   = (head_reg[q] == HW'(FIFO_DEPTH - 1)) ?
                                         '0 : head_reg[q] + HW'(1);
                        count_next[q]  = count_reg[q] - CW'(1);
                        sstart_next[q] = best_reg;
                        comp_next[q]   = tsqes_pkg::time_add_sat(best_reg, sv_reg);
                    end
                end
                wcnt32      = 32'(count_next[q]);
                m_wcnt_next = wcnt32[tsqes_pkg::WCOUNT_W-1:0];
            end
        end

        // Configuration writes; a first arrival write reschedules that arrival.
        if (cfg_fire) begin
            unique case (tsqes_pkg::cfg_index_t'(cfg_index))
                tsqes_pkg::CFG_FIRST_Q0: begin
                    arr_next[0] = TW'(cfg_data);
                end
                tsqes_pkg::CFG_FIRST_Q1: begin
                    arr_next[1] = TW'(cfg_data);
                end
                tsqes_pkg::CFG_TOTAL: begin
                    total_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= tsqes_pkg::TOTAL_RST;
            sim_clock_reg <= '0;
            for (int k = 0; k < 2; k++) begin
                arr_reg[k]    <= TW'(tsqes_pkg::FIRST_ARRIVAL_RST);
                busy_reg[k]   <= 1'b0;
                comp_reg[k]   <= '0;
                sarr_reg[k]   <= '0;
                sstart_reg[k] <= '0;
                head_reg[k]   <= '0;
                count_reg[k]  <= '0;
            end
            dep_reg     <= '0;
            exec_reg    <= 1'b0;
            pop_reg     <= 1'b0;
            popq_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            sim_clock_reg <= sim_clock_next;
            for (int k = 0; k < 2; k++) begin
                arr_reg[k]    <= arr_next[k];
                busy_reg[k]   <= busy_next[k];
                comp_reg[k]   <= comp_next[k];
                sarr_reg[k]   <= sarr_next[k];
                sstart_reg[k] <= sstart_next[k];
                head_reg[k]   <= head_next[k];
                count_reg[k]  <= count_next[k];
            end
            dep_reg     <= dep_next;
            exec_reg    <= exec_next;
            pop_reg     <= pop_next;
            popq_reg    <= popq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: pick results and output fields.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            fin_reg  <= (dep_reg >= total_reg);
            sel_reg  <= pick_sel;
            best_reg <= pick_t;
            ia_reg   <= s_tdata[31:0];
            sv_reg   <= s_tdata[63:32];
        end
        m_kind_reg <= m_kind_next;
        m_q_reg    <= m_q_next;
        m_time_reg <= m_time_next;
        m_resp_reg <= m_resp_next;
        m_wait_reg <= m_wait_next;
        m_serv_reg <= m_serv_next;
        m_wcnt_reg <= m_wcnt_next;
        m_done_reg <= m_done_next;
    end

    // ---------------- outputs ----------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_wcnt_reg, m_serv_reg, m_wait_reg, m_resp_reg, m_time_reg};
    assign m_tuser  = {m_done_reg, m_q_reg, m_kind_reg};

endmodule

FILE: hw/rtl/tsqes_ram.sv
// Generic simple dual-port RAM with registered read.
module tsqes_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
